### rtl/pidsf_pkg.sv
// shared types, constants and microcode rom of the pid controller
package pidsf_pkg;

  // field and datapath widths
  localparam int unsigned DataW    = 16;
  localparam int unsigned GainW    = 32;
  localparam int unsigned CfgW     = 47;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned ErrW     = DataW + 1;
  localparam int unsigned IntegW   = 48;
  localparam int unsigned ProdW    = 57;
  localparam int unsigned AccW     = 58;
  localparam int unsigned DivW     = 48;
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned SumW     = 48;

  // reset values and fixed-point constants
  localparam logic signed [DataW-1:0] PrevReset  = 16'sd2400;
  localparam logic [CfgW-1:0]         LimitReset = {CfgW{1'b1}};
  localparam logic signed [SumW-1:0]  HalfQ16    = 48'sd32768;
  localparam logic signed [ProdW-1:0] IntegSatHi = 57'sd4294967296;
  localparam logic signed [ProdW-1:0] IntegSatLo = -57'sd4294967296;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_INTEG_LIMIT = 3'd4
  } cfg_reg_e;

  // request and result payloads
  typedef struct packed {
    logic signed [DataW-1:0] measurement;
    logic [DataW-1:0]        elapsed_seconds;
  } in_item_t;

  typedef struct packed {
    logic signed [GainW-1:0] drive;
    logic                    zero_interval;
  } out_item_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_EL,
    MUL_KP_ERR,
    MUL_KI_LO,
    MUL_KI_HI,
    MUL_KD_DELTA
  } mul_sel_e;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD_PROD,
    ACC_ADD_QUO
  } acc_op_e;

  // jump conditions of the sequencer
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_NO_REQ,
    JMP_ZERO,
    JMP_DIV_BUSY,
    JMP_OUT_BUSY
  } jump_e;

  // program steps
  typedef enum logic [3:0] {
    PC_IDLE,
    PC_ERR_EL,
    PC_INTEG,
    PC_ADD_P,
    PC_ADD_KI_LO,
    PC_LOAD_KI_HI,
    PC_DIV_LOAD,
    PC_DIV_ITER,
    PC_ADD_D,
    PC_FINISH
  } pc_e;

  // one control word of the program
  typedef struct packed {
    logic     load_req;
    mul_sel_e mul;
    logic     integ_upd;
    acc_op_e  acc;
    logic     a_load;
    logic     div_load;
    logic     div_step;
    logic     out_load;
    jump_e    jmp;
    pc_e      target;
    logic     seq_end;
  } ctrl_word_t;

  // microcode rom
  function automatic ctrl_word_t ucode(input pc_e pc);
    ctrl_word_t w;
    w = '0;
    w.mul    = MUL_NONE;
    w.acc    = ACC_HOLD;
    w.jmp    = JMP_NEVER;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE: begin
        w.load_req = 1'b1;
        w.acc      = ACC_CLEAR;
        w.jmp      = JMP_NO_REQ;
        w.target   = PC_IDLE;
      end
      PC_ERR_EL: begin
        w.mul = MUL_ERR_EL;
      end
      PC_INTEG: begin
        w.integ_upd = 1'b1;
        w.mul       = MUL_KP_ERR;
      end
      PC_ADD_P: begin
        w.acc = ACC_ADD_PROD;
        w.mul = MUL_KI_LO;
      end
      PC_ADD_KI_LO: begin
        w.acc = ACC_ADD_PROD;
        w.mul = MUL_KI_HI;
      end
      PC_LOAD_KI_HI: begin
        w.a_load = 1'b1;
        w.mul    = MUL_KD_DELTA;
        w.jmp    = JMP_ZERO;
        w.target = PC_FINISH;
      end
      PC_DIV_LOAD: begin
        w.div_load = 1'b1;
      end
      PC_DIV_ITER: begin
        w.div_step = 1'b1;
        w.jmp      = JMP_DIV_BUSY;
        w.target   = PC_DIV_ITER;
      end
      PC_ADD_D: begin
        w.acc = ACC_ADD_QUO;
      end
      PC_FINISH: begin
        w.out_load = 1'b1;
        w.jmp      = JMP_OUT_BUSY;
        w.target   = PC_FINISH;
        w.seq_end  = 1'b1;
      end
      default: begin
        w.seq_end = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/pid_controller_standard_form_unit.sv
// pid controller top level: microcoded sequencer over one multiplier and a serial divider
//
// Usage: measurement requests (signed Q12.4 measurement, whole elapsed seconds) enter on
// in_valid_i/in_ready_o; one result request (Q16.16 drive, zero_interval flag) leaves on
// out_valid_o/out_ready_i. Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
// while no request is in flight; writing the setpoint clears the integral.
// The derivative term runs through the restoring divider, one quotient bit per cycle over
// 48 bits, skipped when elapsed_seconds is 0; the steps before the divider each use the
// shared 32x25 multiplier once.
// Flow: one request at a time; in_ready_o rises again at the edge that loads the result.
// The result sits in an output register: while the receiver stalls, the next request
// is still taken and runs until its result is ready, then waits in the final step.
// Reset: gains and setpoint 0, integral limit all ones, integral 0, previous
// measurement 150.0, no result pending, sequencer idle.
module pid_controller_standard_form_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pidsf_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pidsf_pkg::out_item_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [pidsf_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [pidsf_pkg::CfgW-1:0]         cfg_wdata_i
);

  // configuration and state registers
  logic signed [pidsf_pkg::DataW-1:0]  setpoint_q, setpoint_d;
  logic signed [pidsf_pkg::GainW-1:0]  kp_q, kp_d, ki_q, ki_d, kd_q, kd_d;
  logic [pidsf_pkg::CfgW-1:0]          limit_q, limit_d;
  logic signed [pidsf_pkg::IntegW-1:0] integ_q, integ_d;
  logic signed [pidsf_pkg::DataW-1:0]  prev_q, prev_d;

  // sequencer
  pidsf_pkg::pc_e        pc_q, pc_d;
  pidsf_pkg::ctrl_word_t cw;
  logic                  jump_take;
  logic                  in_fire;
  logic                  out_busy;
  logic                  div_busy;

  // datapath registers
  logic signed [pidsf_pkg::ErrW-1:0]   err_q, err_d, delta_q, delta_d;
  logic [pidsf_pkg::DataW-1:0]         el_q, el_d;
  logic                                zero_q, zero_d;
  logic signed [pidsf_pkg::ProdW-1:0]  prod_q, prod_d, a_q, a_d;
  logic signed [pidsf_pkg::AccW-1:0]   acc_q, acc_d;
  logic [pidsf_pkg::DataW-1:0]         rem_q, rem_d;
  logic [pidsf_pkg::DivW-1:0]          quo_q, quo_d;
  logic [pidsf_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic                                neg_q, neg_d;
  logic                                out_valid_q, out_valid_d;
  pidsf_pkg::out_item_t                out_q, out_d;

  // combinational helpers
  logic [pidsf_pkg::GainW-1:0]         mul_a;
  logic [24:0]                         mul_b;
  logic signed [pidsf_pkg::ProdW-1:0]  mul_p;
  logic signed [pidsf_pkg::IntegW:0]   integ_sum, lim_pos, lim_neg, integ_clamp;
  logic signed [pidsf_pkg::ProdW-1:0]  prod_mag;
  logic [pidsf_pkg::DataW:0]           trial;
  logic                                fits;
  logic signed [pidsf_pkg::DivW:0]     quo_signed;
  logic signed [pidsf_pkg::SumW-1:0]   t_sum;
  logic signed [pidsf_pkg::GainW-1:0]  drive;

  // control word fetch and handshake terms
  assign cw         = pidsf_pkg::ucode(pc_q);
  assign in_ready_o = cw.load_req;
  assign in_fire    = cw.load_req & in_valid_i;
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign div_busy   = (cnt_q != '0);

  // next step: conditional jump, end of program or fall through
  always_comb begin
    case (cw.jmp)
      pidsf_pkg::JMP_NEVER:    jump_take = 1'b0;
      pidsf_pkg::JMP_NO_REQ:   jump_take = ~in_valid_i;
      pidsf_pkg::JMP_ZERO:     jump_take = zero_q;
      pidsf_pkg::JMP_DIV_BUSY: jump_take = div_busy;
      pidsf_pkg::JMP_OUT_BUSY: jump_take = out_busy;
      default:                 jump_take = 1'b0;
    endcase
    if (jump_take) begin
      pc_d = cw.target;
    end else if (cw.seq_end) begin
      pc_d = pidsf_pkg::PC_IDLE;
    end else begin
      pc_d = pidsf_pkg::pc_e'(pc_q + 4'd1);
    end
  end

  // configuration writes
  always_comb begin
    setpoint_d = setpoint_q;
    kp_d       = kp_q;
    ki_d       = ki_q;
    kd_d       = kd_q;
    limit_d    = limit_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        pidsf_pkg::REG_SETPOINT:    setpoint_d = cfg_wdata_i[pidsf_pkg::DataW-1:0];
        pidsf_pkg::REG_GAIN_P:      kp_d       = cfg_wdata_i[pidsf_pkg::GainW-1:0];
        pidsf_pkg::REG_GAIN_I:      ki_d       = cfg_wdata_i[pidsf_pkg::GainW-1:0];
        pidsf_pkg::REG_GAIN_D:      kd_d       = cfg_wdata_i[pidsf_pkg::GainW-1:0];
        pidsf_pkg::REG_INTEG_LIMIT: limit_d    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request capture: error, measurement delta and interval
  always_comb begin
    err_d   = err_q;
    delta_d = delta_q;
    el_d    = el_q;
    zero_d  = zero_q;
    prev_d  = prev_q;
    if (in_fire) begin
      err_d   = {in_data_i.measurement[pidsf_pkg::DataW-1], in_data_i.measurement}
              - {setpoint_q[pidsf_pkg::DataW-1], setpoint_q};
      delta_d = {in_data_i.measurement[pidsf_pkg::DataW-1], in_data_i.measurement}
              - {prev_q[pidsf_pkg::DataW-1], prev_q};
      el_d    = in_data_i.elapsed_seconds;
      zero_d  = (in_data_i.elapsed_seconds == '0);
      prev_d  = in_data_i.measurement;
    end
  end

  // shared signed multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      pidsf_pkg::MUL_ERR_EL: begin
        mul_a = {{15{err_q[16]}}, err_q};
        mul_b = {9'b0, el_q};
      end
      pidsf_pkg::MUL_KP_ERR: begin
        mul_a = kp_q;
        mul_b = {{8{err_q[16]}}, err_q};
      end
      pidsf_pkg::MUL_KI_LO: begin
        mul_a = ki_q;
        mul_b = {1'b0, integ_q[23:0]};
      end
      pidsf_pkg::MUL_KI_HI: begin
        mul_a = ki_q;
        mul_b = {integ_q[47], integ_q[47:24]};
      end
      pidsf_pkg::MUL_KD_DELTA: begin
        mul_a = kd_q;
        mul_b = {{8{delta_q[16]}}, delta_q};
      end
      default: ;
    endcase
    mul_p  = $signed({{25{mul_a[31]}}, mul_a}) * $signed({{32{mul_b[24]}}, mul_b});
    prod_d = (cw.mul != pidsf_pkg::MUL_NONE) ? mul_p : prod_q;
  end

  // integral update with clamp to plus or minus the limit
  always_comb begin
    integ_sum = {integ_q[pidsf_pkg::IntegW-1], integ_q} + {{15{prod_q[33]}}, prod_q[33:0]};
    lim_pos   = {2'b00, limit_q};
    lim_neg   = -lim_pos;
    if (integ_sum < lim_neg) begin
      integ_clamp = lim_neg;
    end else if (integ_sum > lim_pos) begin
      integ_clamp = lim_pos;
    end else begin
      integ_clamp = integ_sum;
    end
    integ_d = integ_q;
    if (cfg_we_i && (cfg_addr_i == pidsf_pkg::REG_SETPOINT)) begin
      integ_d = '0;
    end else if (cw.integ_upd) begin
      integ_d = integ_clamp[pidsf_pkg::IntegW-1:0];
    end
  end

  // restoring divider for the derivative term, one quotient bit per cycle
  always_comb begin
    prod_mag   = prod_q[pidsf_pkg::ProdW-1] ? -prod_q : prod_q;
    trial      = {rem_q, quo_q[pidsf_pkg::DivW-1]};
    fits       = (trial >= {1'b0, el_q});
    quo_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    if (cw.div_load) begin
      rem_d = '0;
      quo_d = prod_mag[pidsf_pkg::DivW-1:0];
      cnt_d = pidsf_pkg::DivCntW'(pidsf_pkg::DivW - 1);
      neg_d = prod_q[pidsf_pkg::ProdW-1];
    end else if (cw.div_step) begin
      rem_d = fits ? 16'(trial - {1'b0, el_q}) : trial[pidsf_pkg::DataW-1:0];
      quo_d = {quo_q[pidsf_pkg::DivW-2:0], fits};
      cnt_d = div_busy ? cnt_q - 1'b1 : cnt_q;
    end
  end

  // accumulator of the low-order terms, and register of the integral high product
  always_comb begin
    case (cw.acc)
      pidsf_pkg::ACC_HOLD:     acc_d = acc_q;
      pidsf_pkg::ACC_CLEAR:    acc_d = '0;
      pidsf_pkg::ACC_ADD_PROD: acc_d = acc_q + {prod_q[pidsf_pkg::ProdW-1], prod_q};
      pidsf_pkg::ACC_ADD_QUO:  acc_d = acc_q + {{9{quo_signed[pidsf_pkg::DivW]}}, quo_signed};
      default:                 acc_d = acc_q;
    endcase
    a_d = cw.a_load ? prod_q : a_q;
  end

  // final sum, floor to Q16.16, half added, saturation
  always_comb begin
    t_sum = {a_q[35:0], 12'b0} + {{2{acc_q[pidsf_pkg::AccW-1]}}, acc_q[pidsf_pkg::AccW-1:12]}
          + pidsf_pkg::HalfQ16;
    if (a_q > pidsf_pkg::IntegSatHi) begin
      drive = 32'sh7FFF_FFFF;
    end else if (a_q < pidsf_pkg::IntegSatLo) begin
      drive = 32'sh8000_0000;
    end else if (t_sum > 48'sh0000_7FFF_FFFF) begin
      drive = 32'sh7FFF_FFFF;
    end else if (t_sum < -48'sh0000_8000_0000) begin
      drive = 32'sh8000_0000;
    end else begin
      drive = t_sum[pidsf_pkg::GainW-1:0];
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cw.out_load && !out_busy) begin
      out_valid_d         = 1'b1;
      out_d.drive         = drive;
      out_d.zero_interval = zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= pidsf_pkg::PC_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      setpoint_q  <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      limit_q     <= pidsf_pkg::LimitReset;
      integ_q     <= '0;
      prev_q      <= pidsf_pkg::PrevReset;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      setpoint_q  <= setpoint_d;
      kp_q        <= kp_d;
      ki_q        <= ki_d;
      kd_q        <= kd_d;
      limit_q     <= limit_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    delta_q <= delta_d;
    el_q    <= el_d;
    zero_q  <= zero_d;
    prod_q  <= prod_d;
    a_q     <= a_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    out_q   <= out_d;
  end

endmodule

### rtl/pidsf_checker.sv
// port checker of the pid controller and its bind to the top level
module pidsf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input pidsf_pkg::in_item_t            in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input pidsf_pkg::out_item_t           out_data_o,
  input logic                           cfg_we_i
);

  // sequencer is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous request still in flight");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while sequencer was idle");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // waiting request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("waiting request dropped or changed");

  // registers are written only while the unit is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !out_valid_o)
    else $error("register written while a request was in flight");

endmodule

bind pid_controller_standard_form_unit pidsf_checker u_pidsf_checker (.*);

### tb/tb_pid_controller_standard_form_unit.sv
// self-checking testbench of the pid controller unit
`timescale 1ns / 1ps

module tb_pid_controller_standard_form_unit;

  // run shape
  localparam int unsigned CycleLimit     = 600000;
  localparam int unsigned DrainCycles    = 64;
  localparam int unsigned HoldOffCycles  = 400;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned ItemsPerPhase  = 166;
  localparam int unsigned PressurePhase  = 2;
  localparam int unsigned PressureItems  = 30;
  localparam int unsigned DirectedRows   = 18;
  localparam int unsigned RegCount       = int'(pidsf_pkg::REG_INTEG_LIMIT) + 1;

  // fixed-point limits of the drive computation
  localparam longint DriveMax       = 64'sd2147483647;
  localparam longint DriveMin       = -64'sd2147483648;
  localparam longint IntegTermBound = 64'sd4294967296;
  localparam longint HalfLsb        = 64'sd32768;
  localparam logic signed [pidsf_pkg::GainW-1:0] HalfDrive = 32'sh0000_8000;

  // directed gain settings
  localparam int KeepSetting = -1;
  localparam int SetModerate = 0;
  localparam int SetHigh     = 1;
  localparam int SetLow      = 2;
  localparam int SetOff      = 3;

  typedef struct packed {
    logic signed [pidsf_pkg::DataW-1:0] setpoint;
    logic signed [pidsf_pkg::GainW-1:0] kp;
    logic signed [pidsf_pkg::GainW-1:0] ki;
    logic signed [pidsf_pkg::GainW-1:0] kd;
    logic [pidsf_pkg::CfgW-1:0]         limit;
  } controller_setting_t;

  typedef struct packed {
    int                                 setting;
    logic signed [pidsf_pkg::DataW-1:0] measurement;
    logic [pidsf_pkg::DataW-1:0]        elapsed_seconds;
    logic                               has_result;
    logic signed [pidsf_pkg::GainW-1:0] drive;
    logic                               zero_interval;
  } directed_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  pidsf_pkg::in_item_t            in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  pidsf_pkg::out_item_t           out_data_o;
  logic                           cfg_we_i;
  logic [pidsf_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [pidsf_pkg::CfgW-1:0]     cfg_wdata_i;

  // controller state mirrored by the predictor
  longint pred_setpoint;
  longint pred_kp;
  longint pred_ki;
  longint pred_kd;
  longint pred_limit;
  longint pred_integral;
  longint pred_last_meas;

  pidsf_pkg::out_item_t expected_drives [$];
  controller_setting_t  directed_settings [4];
  directed_row_t        directed_rows [DirectedRows];
  int unsigned          mismatch_count    = 0;
  int unsigned          cycle_count       = 0;
  int unsigned          hold_off_requests = 0;
  bit                   idle_enabled      = 1'b1;

  pid_controller_standard_form_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // expected drive of one request, advances the mirrored state
  function automatic pidsf_pkg::out_item_t predict_drive(input pidsf_pkg::in_item_t req);
    longint               meas;
    longint               span;
    longint               err;
    longint               integ;
    longint               p_term;
    longint               d_term;
    longint               hi;
    longint               lo;
    longint               i_hi;
    longint               total;
    pidsf_pkg::out_item_t res;
    meas  = longint'($signed(req.measurement));
    span  = longint'(req.elapsed_seconds);
    err   = meas - pred_setpoint;
    // integrator with clamp
    integ = pred_integral + err * span;
    if (integ < -pred_limit) integ = -pred_limit;
    if (integ > pred_limit) integ = pred_limit;
    pred_integral = integ;
    p_term = pred_kp * err;
    d_term = (span == 0) ? 64'sd0 : (pred_kd * (meas - pred_last_meas)) / span;
    // split integral so the upper product cannot overflow
    hi   = integ >>> 24;
    lo   = integ - (hi <<< 24);
    i_hi = pred_ki * hi;
    if (i_hi > IntegTermBound) begin
      total = DriveMax;
    end else if (i_hi < -IntegTermBound) begin
      total = DriveMin;
    end else begin
      total = i_hi * 4096 + ((pred_ki * lo + p_term + d_term) >>> 12) + HalfLsb;
      if (total > DriveMax) total = DriveMax;
      if (total < DriveMin) total = DriveMin;
    end
    pred_last_meas    = meas;
    res.drive         = total[pidsf_pkg::GainW-1:0];
    res.zero_interval = (span == 0);
    return res;
  endfunction

  function automatic logic signed [pidsf_pkg::GainW-1:0] random_gain();
    case ($urandom_range(0, 4))
      0: return pidsf_pkg::GainW'($urandom);
      1: return pidsf_pkg::GainW'($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      3: return pidsf_pkg::GainW'($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
      default: return '0;
    endcase
  endfunction

  function automatic controller_setting_t random_setting();
    controller_setting_t s;
    logic [63:0]         r;
    r = {$urandom, $urandom};
    s.setpoint = pidsf_pkg::DataW'($urandom);
    s.kp       = random_gain();
    s.ki       = random_gain();
    s.kd       = random_gain();
    case ($urandom_range(0, 3))
      0: s.limit = '0;
      1: s.limit = '1;
      2: s.limit = pidsf_pkg::CfgW'($urandom_range(0, 200000));
      default: s.limit = r[pidsf_pkg::CfgW-1:0];
    endcase
    return s;
  endfunction

  // measurements mostly near the setpoint, short intervals mostly
  function automatic pidsf_pkg::in_item_t random_request(
      input logic signed [pidsf_pkg::DataW-1:0] target);
    pidsf_pkg::in_item_t req;
    if ($urandom_range(0, 2) == 0) begin
      req.measurement = pidsf_pkg::DataW'($urandom);
    end else begin
      req.measurement = target + pidsf_pkg::DataW'($urandom_range(0, 400)) - 16'sd200;
    end
    case ($urandom_range(0, 9))
      0: req.elapsed_seconds = '0;
      1: req.elapsed_seconds = pidsf_pkg::DataW'($urandom);
      default: req.elapsed_seconds = pidsf_pkg::DataW'($urandom_range(1, 8));
    endcase
    return req;
  endfunction

  // register write, keeps the enable high for a following write
  task automatic write_register(input logic [pidsf_pkg::CfgAddrW-1:0] index,
                                input logic [pidsf_pkg::CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (index)
      pidsf_pkg::REG_SETPOINT: begin
        pred_setpoint = longint'($signed(value[pidsf_pkg::DataW-1:0]));
        pred_integral = 0;
      end
      pidsf_pkg::REG_GAIN_P:      pred_kp    = longint'($signed(value[pidsf_pkg::GainW-1:0]));
      pidsf_pkg::REG_GAIN_I:      pred_ki    = longint'($signed(value[pidsf_pkg::GainW-1:0]));
      pidsf_pkg::REG_GAIN_D:      pred_kd    = longint'($signed(value[pidsf_pkg::GainW-1:0]));
      pidsf_pkg::REG_INTEG_LIMIT: pred_limit = longint'(value);
      default: ;
    endcase
  endtask

  // all registers, junk in unused upper bits, then an unmapped index
  task automatic apply_setting(input controller_setting_t s);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_register(pidsf_pkg::REG_SETPOINT,
                   {noise[pidsf_pkg::CfgW-1:pidsf_pkg::DataW], s.setpoint});
    write_register(pidsf_pkg::REG_GAIN_P,
                   {noise[pidsf_pkg::CfgW-1:pidsf_pkg::GainW], s.kp});
    write_register(pidsf_pkg::REG_GAIN_I,
                   {noise[pidsf_pkg::CfgW-pidsf_pkg::GainW+15:16], s.ki});
    write_register(pidsf_pkg::REG_GAIN_D,
                   {noise[pidsf_pkg::CfgW-pidsf_pkg::GainW+31:32], s.kd});
    write_register(pidsf_pkg::REG_INTEG_LIMIT, s.limit);
    write_register(pidsf_pkg::CfgAddrW'($urandom_range(RegCount, 2**pidsf_pkg::CfgAddrW - 1)),
                   noise[pidsf_pkg::CfgW-1:0]);
    cfg_we_i <= 1'b0;
  endtask

  // offer one request, record its expected result on acceptance
  task automatic send_request(input pidsf_pkg::in_item_t req, input bit use_typed,
                              input pidsf_pkg::out_item_t typed_result);
    pidsf_pkg::out_item_t predicted;
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_drive(req);
    expected_drives.push_back(use_typed ? typed_result : predicted);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && holds_served != hold_off_requests) begin
        holds_served++;
        stall_left = HoldOffCycles;
      end else if (stall_left == 0 && idle_enabled && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    pidsf_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual drive %h zero_interval %b",
                 $time, out_data_o.drive, out_data_o.zero_interval);
        mismatch_count++;
      end else begin
        want = expected_drives.pop_front();
        if (out_data_o.drive !== want.drive) begin
          $display("%0t: drive mismatch: expected %h, actual %h",
                   $time, want.drive, out_data_o.drive);
          mismatch_count++;
        end
        if (out_data_o.zero_interval !== want.zero_interval) begin
          $display("%0t: zero_interval mismatch: expected %b, actual %b",
                   $time, want.zero_interval, out_data_o.zero_interval);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    pidsf_pkg::in_item_t  req;
    pidsf_pkg::out_item_t typed_result;
    controller_setting_t  setting;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= '0;
    cfg_wdata_i <= '0;

    // state after reset
    pred_setpoint  = 0;
    pred_kp        = 0;
    pred_ki        = 0;
    pred_kd        = 0;
    pred_limit     = longint'(pidsf_pkg::LimitReset);
    pred_integral  = 0;
    pred_last_meas = longint'(pidsf_pkg::PrevReset);

    // moderate gains, opposite extremes, and all gains off
    directed_settings = '{
      '{16'sd1600, 32'sh0100_0000, 32'sh0004_0000, 32'sh0080_0000, 47'd50000},
      '{16'sh8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, {pidsf_pkg::CfgW{1'b1}}},
      '{16'sh7FFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, {pidsf_pkg::CfgW{1'b0}}},
      '{16'sd0,    32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, {pidsf_pkg::CfgW{1'b1}}}
    };

    directed_rows = '{
      // first request sees the reset value of the previous measurement
      '{SetModerate, 16'sd2560,   16'd2,     1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd3000,   16'd1,     1'b0, 32'sd0,    1'b0},
      // zero interval
      '{KeepSetting, 16'sd3000,   16'd0,     1'b0, 32'sd0,    1'b0},
      // integral driven into the lower and upper clamp
      '{KeepSetting, -16'sd1000,  16'd500,   1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd30000,  16'd65535, 1'b0, 32'sd0,    1'b0},
      // setpoint rewrite clears the integral
      '{SetModerate, 16'sd1600,   16'd1,     1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd1700,   16'd3,     1'b0, 32'sd0,    1'b0},
      // extreme gains, large integral term saturates
      '{SetHigh,     16'sd32767,  16'd65535, 1'b0, 32'sd0,    1'b0},
      '{KeepSetting, -16'sd32768, 16'd1,     1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd32767,  16'd1,     1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd0,      16'd0,     1'b0, 32'sd0,    1'b0},
      '{SetLow,      -16'sd32768, 16'd65535, 1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd32767,  16'd0,     1'b0, 32'sd0,    1'b0},
      '{KeepSetting, 16'sd12345,  16'd3,     1'b0, 32'sd0,    1'b0},
      // gains off: only the rounding half remains
      '{SetOff,      16'sd32767,  16'd65535, 1'b1, HalfDrive, 1'b0},
      '{KeepSetting, -16'sd32768, 16'd0,     1'b1, HalfDrive, 1'b1},
      '{KeepSetting, 16'sd0,      16'd1,     1'b1, HalfDrive, 1'b0},
      '{KeepSetting, -16'sd1,     16'd65535, 1'b1, HalfDrive, 1'b0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests
    foreach (directed_rows[r]) begin
      if (directed_rows[r].setting != KeepSetting) begin
        wait_for_drain();
        apply_setting(directed_settings[directed_rows[r].setting]);
      end
      req.measurement            = directed_rows[r].measurement;
      req.elapsed_seconds        = directed_rows[r].elapsed_seconds;
      typed_result.drive         = directed_rows[r].drive;
      typed_result.zero_interval = directed_rows[r].zero_interval;
      send_request(req, directed_rows[r].has_result, typed_result);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RandomPhases; p++) begin
      wait_for_drain();
      setting = random_setting();
      apply_setting(setting);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        idle_enabled = !(p == RandomPhases - 1 || (p == PressurePhase && n < PressureItems));
        if (p == PressurePhase && n == 0) hold_off_requests++;
        send_request(random_request(setting.setpoint), 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
